>>> hw/rtl/gdo_pkg.sv
// Package for the ground-driven oscillator step core.
// Holds the widths, register indexes, register resets and sequencer states used by the interfaces and the step core.
package gdo_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int QW = 32;
	localparam int CFG_W = 31;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_SPRING = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DAMPING = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIVISOR = 2'd2;

	localparam logic [30:0] SPRING_RST = 31'd1310720;
	localparam logic [30:0] DAMPING_RST = 31'd655360;
	localparam logic [15:0] DIVISOR_RST = 16'd100;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DIVQ, ST_DIVM, ST_DIVA, ST_MKP, ST_MBV, ST_MGD,
		ST_MAVG, ST_OUT
	} state_t;
endpackage

>>> hw/rtl/gdo_if.sv
// Valid/ready channel interfaces for the step core.
// Depends on gdo_pkg for the field widths.
interface gdo_in_if import gdo_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [QW-1:0] sample_time;
	logic signed [QW-1:0] ground_displacement;
	logic start_record;
	modport source (output valid, sample_time, ground_displacement, start_record, input ready);
	modport sink (input valid, sample_time, ground_displacement, start_record, output ready);
endinterface

interface gdo_out_if import gdo_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [QW-1:0] row_time;
	logic signed [QW-1:0] row_displacement;
	logic signed [QW-1:0] ground_acceleration;
	logic signed [QW-1:0] building_position;
	logic signed [QW-1:0] building_velocity;
	logic arithmetic_fault;
	modport source (output valid, row_time, row_displacement, ground_acceleration,
		building_position, building_velocity, arithmetic_fault, input ready);
	modport sink (input valid, row_time, row_displacement, ground_acceleration,
		building_position, building_velocity, arithmetic_fault, output ready);
endinterface

>>> hw/rtl/ground_driven_oscillator_step_core.sv
// Ground-driven oscillator step: one step per ground displacement sample.
// Depends on gdo_pkg, gdo_if, gdo_div and gdo_mul.
//
// Usage: samples come in on the in channel (valid/ready); rows leave on the out
// channel. The first sample of a record (start_record or first after reset) gives
// row zero, which can be handed on in the cycle after the sample is taken. The second
// sample gives no row. Every further sample gives the row of the previous sample.
// Such a step runs a bit-serial divider three times (divisor, dt, dt) and a
// two-bit-per-cycle multiplier four times before its row can be handed on; when dt is
// zero, the last two divides are skipped. The next sample can be taken in the cycle
// after the row is handed on.
// The result sits in an output register; a stalled receiver holds the row and the
// block waits. Reset clears phase, state and restores register defaults.
// Configuration is to be written by the user only while idle; the block itself does not enforce it.
module ground_driven_oscillator_step_core import gdo_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0] cfg_wdata,
	gdo_in_if.sink in_ch,
	gdo_out_if.source out_ch
);
	localparam logic signed [63:0] LIM = 64'sd1 <<< (62 - FRAC_BITS);
	localparam logic signed [63:0] SMAX = 64'sd2147483647;
	localparam logic signed [63:0] SMIN = -64'sd2147483648;

	state_t st_q, st_d;
	logic [30:0] k_q, b_q;
	logic [15:0] div_q;
	logic [1:0] phase_q;
	logic signed [31:0] ot_q, ht_q, od_q, hd_q, pa_q, pos_q, vel_q, nt_q, nd_q;
	logic signed [31:0] dt_q, acc_q, g_q, nv_q;
	logic signed [63:0] q_q, kp_q;
	logic flt_q;
	logic signed [31:0] o_t, o_d, o_a, o_p, o_v;
	logic o_f;

	logic div_start, div_busy, div_done;
	logic mul_start, mul_busy, mul_done;
	logic signed [63:0] dnum, dden, dquo;
	logic signed [31:0] ma, mb;
	logic signed [63:0] mprod, mshift;

	gdo_div #(.W(64)) u_div (.clk, .arst_n, .start(div_start), .num(dnum), .den(dden),
		.busy(div_busy), .done(div_done), .quo(dquo));
	gdo_mul u_mul (.clk, .arst_n, .start(mul_start), .a(ma), .b(mb),
		.busy(mul_busy), .done(mul_done), .prod(mprod));

	assign mshift = mprod >>> FRAC_BITS;

	function automatic logic signed [31:0] sat(input logic signed [63:0] x);
		if (x > SMAX) return 32'sh7fffffff;
		if (x < SMIN) return 32'sh80000000;
		return x[31:0];
	endfunction

	function automatic logic ovf(input logic signed [63:0] x);
		return (x > SMAX) || (x < SMIN);
	endfunction

	logic acc_in, new_rec;
	assign in_ch.ready = (st_q == ST_IDLE) && !out_ch.valid;
	assign acc_in = in_ch.valid && in_ch.ready;
	assign new_rec = in_ch.start_record || (phase_q == 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_IDLE;
		else st_q <= st_d;
	end

	logic signed [63:0] dsum;
	logic [15:0] divn;
	assign divn = (div_q == '0) ? 16'd1 : div_q;
	assign dsum = 64'(nd_q) - (64'(hd_q) <<< 1) + 64'(od_q);

	always_comb begin
		st_d = st_q;
		div_start = 1'b0;
		mul_start = 1'b0;
		dnum = dsum;
		dden = 64'(divn);
		ma = 32'(k_q);
		mb = pos_q;
		case (st_q)
			ST_IDLE: begin
				if (acc_in && !new_rec && phase_q == 2'd2) begin
					st_d = ST_DIVQ;
				end
			end
			ST_DIVQ: begin
				if (!div_busy && !div_done) div_start = 1'b1;
				if (div_done) st_d = ST_DIVM;
			end
			ST_DIVM: begin
				dnum = q_q <<< FRAC_BITS;
				dden = 64'(dt_q);
				if (dt_q == '0) st_d = ST_MKP;
				else begin
					if (!div_busy && !div_done) div_start = 1'b1;
					if (div_done) st_d = ST_DIVA;
				end
			end
			ST_DIVA: begin
				dnum = kp_q <<< FRAC_BITS;
				dden = 64'(dt_q);
				if (!div_busy && !div_done) div_start = 1'b1;
				if (div_done) st_d = ST_MKP;
			end
			ST_MKP: begin
				ma = 32'(k_q);
				mb = pos_q;
				if (!mul_busy && !mul_done) mul_start = 1'b1;
				if (mul_done) st_d = ST_MBV;
			end
			ST_MBV: begin
				ma = 32'(b_q);
				mb = vel_q;
				if (!mul_busy && !mul_done) mul_start = 1'b1;
				if (mul_done) st_d = ST_MGD;
			end
			ST_MGD: begin
				ma = g_q;
				mb = dt_q;
				if (!mul_busy && !mul_done) mul_start = 1'b1;
				if (mul_done) st_d = ST_MAVG;
			end
			ST_MAVG: begin
				ma = 32'((64'(vel_q) + 64'(nv_q)) >>> 1);
				mb = dt_q;
				if (!mul_busy && !mul_done) mul_start = 1'b1;
				if (mul_done) st_d = ST_OUT;
			end
			ST_OUT: st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	logic signed [63:0] dtw, gw, vw, pw, mid;
	assign dtw = 64'(ht_q) - 64'(ot_q);
	assign gw = 64'(pa_q) - kp_q - mshift;
	assign vw = 64'(vel_q) + mshift;
	assign pw = 64'(pos_q) + mshift;
	assign mid = (dquo > LIM) ? LIM : ((dquo < -LIM) ? -LIM : dquo);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= SPRING_RST;
			b_q <= DAMPING_RST;
			div_q <= DIVISOR_RST;
			phase_q <= 2'd0;
			ot_q <= '0; ht_q <= '0; od_q <= '0; hd_q <= '0;
			pa_q <= '0; pos_q <= '0; vel_q <= '0;
			out_ch.valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_SPRING: k_q <= cfg_wdata;
					REG_DAMPING: b_q <= cfg_wdata;
					REG_DIVISOR: div_q <= cfg_wdata[15:0];
					default: ;
				endcase
			end
			if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
			if (acc_in) begin
				if (new_rec) begin
					ht_q <= in_ch.sample_time; hd_q <= in_ch.ground_displacement;
					ot_q <= '0; od_q <= '0; pa_q <= '0; pos_q <= '0; vel_q <= '0;
					phase_q <= 2'd1;
					o_t <= in_ch.sample_time; o_d <= in_ch.ground_displacement;
					o_a <= '0; o_p <= '0; o_v <= '0; o_f <= 1'b0;
					out_ch.valid <= 1'b1;
				end else if (phase_q == 2'd1) begin
					ot_q <= ht_q; od_q <= hd_q;
					ht_q <= in_ch.sample_time; hd_q <= in_ch.ground_displacement;
					phase_q <= 2'd2;
				end
			end
			if (st_q == ST_OUT) begin
				o_t <= ht_q; o_d <= hd_q; o_a <= acc_q; o_p <= pos_q; o_v <= nv_q;
				o_f <= flt_q;
				out_ch.valid <= 1'b1;
				pa_q <= acc_q; vel_q <= nv_q;
				ot_q <= ht_q; od_q <= hd_q; ht_q <= nt_q; hd_q <= nd_q;
			end
			if (st_q == ST_MAVG && mul_done) pos_q <= sat(pw);
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && acc_in) begin
			nt_q <= in_ch.sample_time;
			nd_q <= in_ch.ground_displacement;
			dt_q <= sat(dtw);
			flt_q <= ovf(dtw);
		end
		if (st_q == ST_DIVQ && div_done) begin
			q_q <= dquo;
			if (dt_q == '0) begin
				flt_q <= 1'b1;
				acc_q <= dquo[63] ? 32'sh80000000 : ((dquo != '0) ? 32'sh7fffffff : '0);
			end
		end
		if (st_q == ST_DIVM && div_done) begin
			kp_q <= mid;
			if (dquo > LIM || dquo < -LIM) flt_q <= 1'b1;
		end
		if (st_q == ST_DIVA && div_done) begin
			acc_q <= sat(dquo);
			if (ovf(dquo)) flt_q <= 1'b1;
		end
		if (st_q == ST_MKP && mul_done) kp_q <= mshift;
		if (st_q == ST_MBV && mul_done) begin
			g_q <= sat(gw);
			if (ovf(gw)) flt_q <= 1'b1;
		end
		if (st_q == ST_MGD && mul_done) begin
			nv_q <= sat(vw);
			if (ovf(vw)) flt_q <= 1'b1;
		end
		if (st_q == ST_MAVG && mul_done && ovf(pw)) flt_q <= 1'b1;
	end

	assign out_ch.row_time = o_t;
	assign out_ch.row_displacement = o_d;
	assign out_ch.ground_acceleration = o_a;
	assign out_ch.building_position = o_p;
	assign out_ch.building_velocity = o_v;
	assign out_ch.arithmetic_fault = o_f;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_IDLE) |-> !in_ch.ready) else $error("input taken while busy");
	a_out_after_step: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_OUT) |=> out_ch.valid) else $error("row not presented");
	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(div_busy && mul_busy)) else $error("divider and multiplier overlap");
endmodule

>>> hw/rtl/gdo_div.sv
// Bit-serial restoring divider, one quotient bit per cycle, truncation toward zero.
// Needs no package; start, busy and done form its handshake.
module gdo_div #(
	parameter int W = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [W-1:0] num,
	input  logic signed [W-1:0] den,
	output logic busy,
	output logic done,
	output logic signed [W-1:0] quo
);
	localparam int CW = $clog2(W + 1);
	logic [W-1:0] q_q, d_q;
	logic [W:0] r_q;
	logic neg_q;
	logic [CW-1:0] cnt_q;
	logic [W:0] trial;
	logic [W:0] rsh;

	assign rsh = {r_q[W-1:0], q_q[W-1]};
	assign trial = rsh - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				cnt_q <= CW'(W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) done <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num[W-1] ? W'(-num) : num;
			d_q <= den[W-1] ? W'(-den) : den;
			r_q <= '0;
			neg_q <= num[W-1] ^ den[W-1];
		end else if (cnt_q != '0) begin
			if (!trial[W]) begin
				r_q <= trial;
				q_q <= {q_q[W-2:0], 1'b1};
			end else begin
				r_q <= rsh;
				q_q <= {q_q[W-2:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign quo = neg_q ? W'(-q_q) : q_q;
endmodule

>>> hw/rtl/gdo_mul.sv
// Bit-serial shift-add multiplier of two signed 32-bit operands, two bits per cycle.
// Needs no package; start, busy and done form its handshake.
module gdo_mul (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output logic busy,
	output logic done,
	output logic signed [63:0] prod
);
	logic [63:0] acc_q, mc_q;
	logic [31:0] mp_q;
	logic [4:0] cnt_q;
	logic [63:0] add0, add1;

	assign add0 = mp_q[0] ? mc_q : '0;
	assign add1 = mp_q[1] ? {mc_q[62:0], 1'b0} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) cnt_q <= 5'd16;
			else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 5'd1) done <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			mc_q <= 64'(a);
			mp_q <= b;
		end else if (cnt_q != '0) begin
			// top bit of the multiplier carries weight -2^31
			if (cnt_q == 5'd1) acc_q <= acc_q + add0 - add1;
			else acc_q <= acc_q + add0 + add1;
			mc_q <= {mc_q[61:0], 2'b00};
			mp_q <= {2'b00, mp_q[31:2]};
		end
	end

	assign busy = (cnt_q != '0);
	assign prod = acc_q;
endmodule
